### hdl/dcrcm_pkg.sv
package dcrcm_pkg;

  localparam logic [1:0] CMD_SRC   = 2'd0;
  localparam logic [1:0] CMD_DST   = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_REJECTED   = 3'd1;
  localparam logic [2:0] ST_NO_CHANNEL = 3'd2;
  localparam logic [2:0] ST_MISALIGNED = 3'd3;
  localparam logic [2:0] ST_SUPERVISOR = 3'd4;
  localparam logic [2:0] ST_TRANSFER   = 3'd5;

  localparam int FrameShift = 7;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  client_id;
    logic [31:0] region_base;
    logic [31:0] region_bytes;
    logic [31:0] offset;
    logic [31:0] length;
    logic [4:0]  channel;
    logic        misaligned_flag;
    logic        supervisor_flag;
    logic        transfer_error_flag;
    logic        block_done_flag;
  } item_t;

  typedef struct packed {
    logic [3:0]  reply_client;
    logic [2:0]  status;
    logic        start_transfer;
    logic [4:0]  granted_channel;
    logic [25:0] frame_count;
    logic [31:0] source_address;
    logic [31:0] destination_address;
  } result_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] offset;
    logic [31:0] length;
  } src_desc_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] offset;
  } dst_desc_t;

  typedef struct packed {
    logic cap;
    logic rd;
    logic sum;
    logic chk;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic drop;
    logic event_item;
    logic request;
    logic out_free;
  } sts_t;

endpackage

### hdl/dma_copy_request_channel_manager_top.sv
// Channel | Beat contents                                       | Direction
// in_     | tuser: command; tdata: descriptor or channel event  | in
// out_    | tdata: reply to client or channel owner             | out
//
// An event, a lone descriptor or a rejected client goes from accept straight to reply.
// A completed descriptor pair steps through accept, descriptor read, address
// sums, range check with channel search, reply; the controller handles one beat at a time.
// Reset clears descriptor presence and channel busy, error and owner state.
// A stalled out_ holds its beat; the next in_ beat is accepted and waits in reply.
module dma_copy_request_channel_manager_top #(
  parameter int CHANNELS = 32,
  parameter int CLIENTS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // client_id[3:0], region_base[35:4], region_bytes[67:36], offset[99:68],
  // length[131:100], channel[136:132], misaligned_flag[137],
  // supervisor_flag[138], transfer_error_flag[139], block_done_flag[140]
  input  logic [143:0] in_tdata,
  // command[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // reply_client[3:0], status[6:4], start_transfer[7], granted_channel[12:8],
  // frame_count[38:13], source_address[70:39], destination_address[102:71]
  output logic [103:0] out_tdata
);
  import dcrcm_pkg::*;

  item_t   in_item;
  result_t out_result;
  ctl_t    ctl;
  sts_t    sts;

  assign in_item.command             = in_tuser;
  assign in_item.client_id           = in_tdata[3:0];
  assign in_item.region_base         = in_tdata[35:4];
  assign in_item.region_bytes        = in_tdata[67:36];
  assign in_item.offset              = in_tdata[99:68];
  assign in_item.length              = in_tdata[131:100];
  assign in_item.channel             = in_tdata[136:132];
  assign in_item.misaligned_flag     = in_tdata[137];
  assign in_item.supervisor_flag     = in_tdata[138];
  assign in_item.transfer_error_flag = in_tdata[139];
  assign in_item.block_done_flag     = in_tdata[140];

  assign out_tdata = {1'b0, out_result.destination_address, out_result.source_address,
                      out_result.frame_count, out_result.granted_channel,
                      out_result.start_transfer, out_result.status,
                      out_result.reply_client};

  dcrcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  dcrcm_dp #(
    .CHANNELS (CHANNELS),
    .CLIENTS  (CLIENTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (out_result)
  );

endmodule

### hdl/dcrcm_ctrl.sv
module dcrcm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dcrcm_pkg::sts_t   sts,
  output dcrcm_pkg::ctl_t   ctl
);
  import dcrcm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SUM   = 5'b00100,
    S_CHECK = 5'b01000,
    S_REPLY = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ctl.cap   = in_tvalid;
        if (in_tvalid && !sts.drop) begin
          state_nxt = (sts.request && !sts.event_item) ? S_READ : S_REPLY;
        end
      end
      S_READ: begin
        ctl.rd    = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        ctl.sum   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        ctl.chk   = 1'b1;
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        ctl.emit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/dcrcm_dp.sv
module dcrcm_dp #(
  parameter int CHANNELS = 32,
  parameter int CLIENTS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dcrcm_pkg::item_t    in_item,
  input  dcrcm_pkg::ctl_t     ctl,
  output dcrcm_pkg::sts_t     sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output dcrcm_pkg::result_t  out_result
);
  import dcrcm_pkg::*;

  localparam int CLIENT_SLOTS = (CLIENTS < 16) ? CLIENTS : 16;
  localparam int CL_IDX_W     = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int CH_IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [8:0] CLIENT_LIM = 9'(CLIENTS);
  localparam logic [5:0] CHAN_LIM   = 6'(CHANNELS);

  typedef enum logic [1:0] {
    K_ACK   = 2'd0,
    K_REJ   = 2'd1,
    K_EVENT = 2'd2,
    K_REQ   = 2'd3
  } kind_t;

  src_desc_t src_mem [CLIENT_SLOTS];
  dst_desc_t dst_mem [CLIENT_SLOTS];
  src_desc_t src_rd_r;
  dst_desc_t dst_rd_r;

  logic [CLIENT_SLOTS-1:0] have_src_r;
  logic [CLIENT_SLOTS-1:0] have_dst_r;
  logic [CHANNELS-1:0]     busy_r;
  logic [2:0]              err_r   [CHANNELS];
  logic [3:0]              owner_r [CHANNELS];

  item_t   item_r;
  kind_t   kind_r;
  kind_t   kind_nxt;
  logic [CL_IDX_W-1:0] in_idx;
  logic    client_ok;
  logic    chan_ok;
  logic    is_src;
  logic    is_dst;
  logic    req_hit;

  logic [32:0] saddr_r;
  logic [32:0] daddr_r;
  logic [31:0] srem_r;
  logic [31:0] drem_r;
  logic        inside_r;
  logic [33:0] send;
  logic [33:0] dend;
  logic        apart;
  logic        fits;
  logic        pass_r;
  logic        free_any;
  logic [CH_IDX_W-1:0] free_idx;
  logic        free_found_r;
  logic [CH_IDX_W-1:0] free_idx_r;

  logic [CH_IDX_W-1:0] ev_ch;
  logic [2:0]  ev_err;
  logic [25:0] frames;
  logic        grant;
  result_t     result_nxt;
  logic        out_tvalid_r;
  result_t     out_result_r;

  assign in_idx    = in_item.client_id[CL_IDX_W-1:0];
  assign client_ok = {5'd0, in_item.client_id} < CLIENT_LIM;
  assign chan_ok   = {1'b0, in_item.channel} < CHAN_LIM;
  assign is_src    = in_item.command == CMD_SRC;
  assign is_dst    = in_item.command == CMD_DST;
  assign req_hit   = client_ok && ((is_src && have_dst_r[in_idx]) ||
                                   (is_dst && have_src_r[in_idx]));

  assign sts.drop       = (in_item.command == CMD_NONE) ||
                          (in_item.command == CMD_EVENT && !chan_ok);
  assign sts.event_item = in_item.command == CMD_EVENT;
  assign sts.request    = req_hit;
  assign sts.out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    if (in_item.command == CMD_EVENT) begin
      kind_nxt = K_EVENT;
    end else if (!client_ok) begin
      kind_nxt = K_REJ;
    end else if (req_hit) begin
      kind_nxt = K_REQ;
    end else begin
      kind_nxt = K_ACK;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      item_r <= in_item;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap && client_ok && is_src) begin
      src_mem[in_idx] <= '{base: in_item.region_base, size: in_item.region_bytes,
                           offset: in_item.offset, length: in_item.length};
    end
    if (ctl.cap && client_ok && is_dst) begin
      dst_mem[in_idx] <= '{base: in_item.region_base, size: in_item.region_bytes,
                           offset: in_item.offset};
    end
    if (ctl.rd) begin
      src_rd_r <= src_mem[item_r.client_id[CL_IDX_W-1:0]];
      dst_rd_r <= dst_mem[item_r.client_id[CL_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_src_r <= '0;
      have_dst_r <= '0;
    end else if (ctl.cap && client_ok && (is_src || is_dst)) begin
      if (req_hit) begin
        have_src_r[in_idx] <= 1'b0;
        have_dst_r[in_idx] <= 1'b0;
      end else if (is_src) begin
        have_src_r[in_idx] <= 1'b1;
      end else begin
        have_dst_r[in_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum) begin
      saddr_r  <= {1'b0, src_rd_r.base} + {1'b0, src_rd_r.offset};
      daddr_r  <= {1'b0, dst_rd_r.base} + {1'b0, dst_rd_r.offset};
      srem_r   <= src_rd_r.size - src_rd_r.offset;
      drem_r   <= dst_rd_r.size - dst_rd_r.offset;
      inside_r <= (src_rd_r.offset < src_rd_r.size) && (dst_rd_r.offset < dst_rd_r.size);
    end
  end

  assign send  = {1'b0, saddr_r} + {2'b00, src_rd_r.length};
  assign dend  = {1'b0, daddr_r} + {2'b00, src_rd_r.length};
  assign apart = ((saddr_r < daddr_r) && (send <= {1'b0, daddr_r})) ||
                 ((daddr_r < saddr_r) && (dend <= {1'b0, saddr_r}));
  assign fits  = (src_rd_r.length <= srem_r) && (src_rd_r.length <= drem_r);

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_any = 1'b1;
        free_idx = CH_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.chk) begin
      pass_r       <= inside_r && apart && fits;
      free_found_r <= free_any;
      free_idx_r   <= free_idx;
    end
  end

  assign ev_ch  = item_r.channel[CH_IDX_W-1:0];
  assign frames = 26'(src_rd_r.length[31:FrameShift]) +
                  26'(|src_rd_r.length[FrameShift-1:0]);
  assign grant  = (kind_r == K_REQ) && pass_r && free_found_r;

  always_comb begin
    ev_err = err_r[ev_ch];
    if (item_r.misaligned_flag) begin
      ev_err = ST_MISALIGNED;
    end
    if (item_r.supervisor_flag) begin
      ev_err = ST_SUPERVISOR;
    end
    if (item_r.transfer_error_flag) begin
      ev_err = ST_TRANSFER;
    end
    if (item_r.block_done_flag) begin
      ev_err = ST_OK;
    end
  end

  always_comb begin
    result_nxt              = '0;
    result_nxt.reply_client = item_r.client_id;
    case (kind_r)
      K_ACK: result_nxt.status = ST_OK;
      K_REJ: result_nxt.status = ST_REJECTED;
      K_EVENT: begin
        result_nxt.reply_client    = owner_r[ev_ch];
        result_nxt.status          = ev_err;
        result_nxt.granted_channel = item_r.channel;
      end
      K_REQ: begin
        if (!pass_r) begin
          result_nxt.status = ST_REJECTED;
        end else if (!free_found_r) begin
          result_nxt.status = ST_NO_CHANNEL;
        end else begin
          result_nxt.status              = ST_OK;
          result_nxt.start_transfer      = 1'b1;
          result_nxt.granted_channel     = 5'(free_idx_r);
          result_nxt.frame_count         = frames;
          result_nxt.source_address      = saddr_r[31:0];
          result_nxt.destination_address = daddr_r[31:0];
        end
      end
      default: result_nxt.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        err_r[i]   <= ST_OK;
        owner_r[i] <= '0;
      end
    end else if (ctl.emit) begin
      if (kind_r == K_EVENT) begin
        err_r[ev_ch] <= ev_err;
        if (item_r.block_done_flag) begin
          busy_r[ev_ch] <= 1'b0;
        end
      end
      if (grant) begin
        busy_r[free_idx_r]  <= 1'b1;
        owner_r[free_idx_r] <= item_r.client_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_result = out_result_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_tvalid_r || out_tready))
    else $error("result overwrote an undelivered beat");

  a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && grant) |=> busy_r[$past(free_idx_r)])
    else $error("granted channel not marked busy");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && kind_r == K_EVENT && item_r.block_done_flag) |=> !busy_r[$past(ev_ch)])
    else $error("block done left channel busy");

endmodule
